>>> rtl/qrt_pkg.sv
package qrt_pkg;

    // number formats
    localparam int COMP_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 13;

    // pipeline lengths
    localparam int CORDIC_STEPS = 30;
    localparam int SQ_STEPS     = 31;
    localparam int DIV_STEPS    = COMP_FRAC_BITS + 1;

    // datapath widths
    localparam int DOT_W  = 34;
    localparam int CW     = 34;
    localparam int SQ_W   = 62;
    localparam int VW     = 48;
    localparam int NORM_W = 30;
    localparam int DW     = NORM_W + COMP_FRAC_BITS + 2;

    // thresholds
    localparam logic [29:0] TINY_SCALE = 30'd1000;
    localparam logic [29:0] TINY_LIM   = 30'(64'd1 << ANGLE_FRAC_BITS);
    localparam logic signed [DOT_W-1:0] DOT_ONE = DOT_W'(64'd1 << (2 * COMP_FRAC_BITS));
    localparam logic signed [DOT_W-1:0] DOT_THR =
        DOT_W'((64'd1 << (2 * COMP_FRAC_BITS))
               - (((64'd1 << (2 * COMP_FRAC_BITS)) + 64'd9999) / 64'd10000));
    localparam int C_SHIFT     = 30 - 2 * COMP_FRAC_BITS;
    localparam int THETA_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam logic [32:0] HALF_PI30 = 33'd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE30 = 34'sd1073741824;
    localparam logic [30:0] ONE30_U = 31'd1073741824;
    localparam logic [5:0] NORM_TOP = 6'd30;
    localparam logic [DIV_STEPS-1:0] MAG_ONE = DIV_STEPS'(64'd1 << COMP_FRAC_BITS);

    typedef enum logic [1:0] {
        OUT_KEEP   = 2'd0,
        OUT_TARGET = 2'd1,
        OUT_STEP   = 2'd2
    } outcome_t;

    // result decided before the partial step path
    typedef struct packed {
        logic            done;
        outcome_t        outc;
        logic [3:0][15:0] res;
    } early_t;

    // restoring square root state
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sq_t;

    function automatic logic signed [CW-1:0] atan_val(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: r = CW'(64'd1 << (30 - i));
        endcase
        return r;
    endfunction

    function automatic logic signed [CW-1:0] clamp30(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ONE30) begin
            r = ONE30;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // one digit of the square root, digit k counted from the top
    function automatic sq_t sq_step(input sq_t cur, input int k);
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        sq_t nxt;
        bitv  = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
        trial = cur.root + bitv;
        if (cur.rem >= trial) begin
            nxt.rem  = cur.rem - trial;
            nxt.root = (cur.root >> 1) + bitv;
        end else begin
            nxt.rem  = cur.rem;
            nxt.root = cur.root >> 1;
        end
        return nxt;
    endfunction

endpackage

>>> rtl/quaternion_rotate_towards_top.sv
// quaternion rotate-towards: turns a start unit quaternion toward a target
// by at most max_angle radians and returns the rotation reached
// input channel: s_valid/s_ready with start (from_*), target (to_*) and
// max_angle; result channel: m_valid/m_ready with res_* and outcome
// (0 start kept, 1 target reached, 2 partial step taken)
// the result passes a 30-step cordic running beside a 31-step square root,
// then a second 31-step square root for the norm and a 15-step divider
// throughput is one item per cycle when not stalled; every stage holds one item
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_ready drops; nothing is lost or repeated, bubbles hold in place too
// reset (aresetn low at a clock edge) clears all stage valid bits; items in
// flight are dropped and the block is ready at the next cycle
module quaternion_rotate_towards_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_from_w,
    input  logic [15:0] s_from_x,
    input  logic [15:0] s_from_y,
    input  logic [15:0] s_from_z,
    input  logic [15:0] s_to_w,
    input  logic [15:0] s_to_x,
    input  logic [15:0] s_to_y,
    input  logic [15:0] s_to_z,
    input  logic [15:0] s_max_angle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_res_w,
    output logic [15:0] m_res_x,
    output logic [15:0] m_res_y,
    output logic [15:0] m_res_z,
    output qrt_pkg::outcome_t m_outcome
);
    import qrt_pkg::*;

    logic en;
    logic out_valid_reg;

    // global advance: the pipeline moves when the output slot is free or taken
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = out_valid_reg;

    // stage 1: component products and tiny step check
    logic                    s1_valid_reg;
    logic [3:0][31:0]        s1_prod_reg;
    logic [3:0][15:0]        s1_a_reg;
    logic [3:0][15:0]        s1_b_reg;
    logic [15:0]             s1_step_reg;
    logic                    s1_tiny_reg;
    logic [3:0][15:0]        in_a;
    logic [3:0][15:0]        in_b;

    assign in_a = {s_from_z, s_from_y, s_from_x, s_from_w};
    assign in_b = {s_to_z, s_to_y, s_to_x, s_to_w};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                s1_prod_reg[k] <= 32'($signed(in_a[k]) * $signed(in_b[k]));
            end
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
            s1_step_reg <= s_max_angle;
            s1_tiny_reg <= (({14'd0, s_max_angle} * TINY_SCALE) < TINY_LIM);
        end
    end

    // stage 2: dot product, early exits, hemisphere fix
    logic                    s2_valid_reg;
    early_t                  s2_e_reg;
    logic [3:0][16:0]        s2_an_reg;
    logic [3:0][15:0]        s2_b_reg;
    logic [30:0]             s2_c_reg;
    logic [30:0]             s2_theta_reg;

    logic signed [DOT_W-1:0] dot;
    logic signed [DOT_W-1:0] dot_abs;
    logic signed [DOT_W-1:0] dot_cl;
    logic                    dot_neg;
    logic [32:0]             theta;
    early_t                  s2_e_next;
    logic [3:0][16:0]        s2_an_next;

    always_comb begin
        dot = '0;
        for (int k = 0; k < 4; k++) begin
            dot = dot + DOT_W'($signed(s1_prod_reg[k]));
        end
        dot_neg = dot[DOT_W-1];
        dot_abs = dot_neg ? -dot : dot;
        dot_cl  = (dot_abs > DOT_ONE) ? DOT_ONE : dot_abs;
        theta   = {s1_step_reg, 17'd0} >> (17 - THETA_SHIFT);
        for (int k = 0; k < 4; k++) begin
            s2_an_next[k] = dot_neg ? -{s1_a_reg[k][15], s1_a_reg[k]}
                                    : {s1_a_reg[k][15], s1_a_reg[k]};
        end
        s2_e_next.done = 1'b1;
        s2_e_next.outc = OUT_TARGET;
        s2_e_next.res  = s1_b_reg;
        priority if (s1_tiny_reg) begin
            s2_e_next.outc = OUT_KEEP;
            s2_e_next.res  = s1_a_reg;
        end else if (dot > DOT_THR) begin
            s2_e_next.done = 1'b1;
        end else if (theta >= HALF_PI30) begin
            s2_e_next.done = 1'b1;
        end else begin
            s2_e_next.done = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_e_reg     <= s2_e_next;
            s2_an_reg    <= s2_an_next;
            s2_b_reg     <= s1_b_reg;
            s2_c_reg     <= 31'(dot_cl << C_SHIFT);
            s2_theta_reg <= theta[30:0];
        end
    end

    // cordic and first square root run side by side, stage 0 is the setup
    logic                    cv_reg  [0:SQ_STEPS];
    early_t                  ce_reg  [0:SQ_STEPS];
    logic [3:0][16:0]        can_reg [0:SQ_STEPS];
    logic [3:0][15:0]        cb_reg  [0:SQ_STEPS];
    logic [30:0]             cc_reg  [0:SQ_STEPS];
    sq_t                     csq_reg [0:SQ_STEPS];
    logic signed [CW-1:0]    cx_reg  [0:SQ_STEPS];
    logic signed [CW-1:0]    cy_reg  [0:SQ_STEPS];
    logic signed [CW-1:0]    cz_reg  [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= s2_valid_reg;
        end
    end

    // radicand 1 - c^2 and cordic start vector
    always_ff @(posedge aclk) begin
        if (en) begin
            ce_reg[0]       <= s2_e_reg;
            can_reg[0]      <= s2_an_reg;
            cb_reg[0]       <= s2_b_reg;
            cc_reg[0]       <= s2_c_reg;
            csq_reg[0].rem  <= (SQ_W'(1) << 60) - SQ_W'(s2_c_reg) * SQ_W'(s2_c_reg);
            csq_reg[0].root <= '0;
            cx_reg[0]       <= CORDIC_GAIN;
            cy_reg[0]       <= '0;
            cz_reg[0]       <= CW'(s2_theta_reg);
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_rot
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;

        // one rotation per stage, the last stage clamps cos and sin
        always_comb begin
            if (k < CORDIC_STEPS) begin
                if (cz_reg[k] >= 0) begin
                    x_next = cx_reg[k] - (cy_reg[k] >>> k);
                    y_next = cy_reg[k] + (cx_reg[k] >>> k);
                    z_next = cz_reg[k] - atan_val(k);
                end else begin
                    x_next = cx_reg[k] + (cy_reg[k] >>> k);
                    y_next = cy_reg[k] - (cx_reg[k] >>> k);
                    z_next = cz_reg[k] + atan_val(k);
                end
            end else begin
                x_next = clamp30(cx_reg[k]);
                y_next = clamp30(cy_reg[k]);
                z_next = cz_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[k+1] <= 1'b0;
            end else if (en) begin
                cv_reg[k+1] <= cv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ce_reg[k+1]  <= ce_reg[k];
                can_reg[k+1] <= can_reg[k];
                cb_reg[k+1]  <= cb_reg[k];
                cc_reg[k+1]  <= cc_reg[k];
                csq_reg[k+1] <= sq_step(csq_reg[k], k);
                cx_reg[k+1]  <= x_next;
                cy_reg[k+1]  <= y_next;
                cz_reg[k+1]  <= z_next;
            end
        end
    end

    // angle test and weight products
    logic                    pv_reg;
    early_t                  pe_reg;
    logic [3:0][16:0]        pan_reg;
    logic [3:0][15:0]        pb_reg;
    logic [30:0]             psn_reg;
    logic [SQ_W-1:0]         pp_reg;
    logic [SQ_W-1:0]         pq_reg;
    logic [30:0]             cos_s;
    logic [30:0]             sin_s;
    logic [30:0]             sin_a;
    early_t                  pe_next;

    assign cos_s = cx_reg[SQ_STEPS][30:0];
    assign sin_s = cy_reg[SQ_STEPS][30:0];
    assign sin_a = csq_reg[SQ_STEPS].root[30:0];

    always_comb begin
        pe_next = ce_reg[SQ_STEPS];
        if (!pe_next.done && (cc_reg[SQ_STEPS] > cos_s)) begin
            pe_next.done = 1'b1;
            pe_next.outc = OUT_TARGET;
            pe_next.res  = cb_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (en) begin
            pv_reg <= cv_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pe_reg  <= pe_next;
            pan_reg <= can_reg[SQ_STEPS];
            pb_reg  <= cb_reg[SQ_STEPS];
            psn_reg <= sin_s;
            pp_reg  <= SQ_W'(sin_a) * SQ_W'(cos_s);
            pq_reg  <= SQ_W'(cc_reg[SQ_STEPS]) * SQ_W'(sin_s);
        end
    end

    // w1 = sin(angle - step), saturated at zero
    logic                    wv_reg;
    early_t                  we_reg;
    logic [3:0][16:0]        wan_reg;
    logic [3:0][15:0]        wb_reg;
    logic [30:0]             wsn_reg;
    logic [30:0]             ww1_reg;
    logic [SQ_W-1:0]         wdiff;

    assign wdiff = (pp_reg - pq_reg) >> 30;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wv_reg <= 1'b0;
        end else if (en) begin
            wv_reg <= pv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            we_reg  <= pe_reg;
            wan_reg <= pan_reg;
            wb_reg  <= pb_reg;
            wsn_reg <= psn_reg;
            ww1_reg <= (pp_reg > pq_reg) ? wdiff[30:0] : '0;
        end
    end

    // weighted component products
    logic                      v1v_reg;
    early_t                    v1e_reg;
    logic [3:0][VW-1:0]        v1pa_reg;
    logic [3:0][VW-1:0]        v1pb_reg;
    logic signed [VW-1:0]      w1_ext;
    logic signed [VW-1:0]      sn_ext;
    logic signed [3:0][VW-1:0] an_ext;
    logic signed [3:0][VW-1:0] b_ext;

    always_comb begin
        w1_ext = {17'd0, ww1_reg};
        sn_ext = {17'd0, wsn_reg};
        for (int k = 0; k < 4; k++) begin
            an_ext[k] = {{(VW-17){wan_reg[k][16]}}, wan_reg[k]};
            b_ext[k]  = {{(VW-16){wb_reg[k][15]}}, wb_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1v_reg <= 1'b0;
        end else if (en) begin
            v1v_reg <= wv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1e_reg <= we_reg;
            for (int k = 0; k < 4; k++) begin
                v1pa_reg[k] <= w1_ext * $signed(an_ext[k]);
                v1pb_reg[k] <= sn_ext * $signed(b_ext[k]);
            end
        end
    end

    // combined vector
    logic                v2v_reg;
    early_t              v2e_reg;
    logic [3:0][VW-1:0]  v2v_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2v_reg <= 1'b0;
        end else if (en) begin
            v2v_reg <= v1v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v2e_reg <= v1e_reg;
            for (int k = 0; k < 4; k++) begin
                v2v_data_reg[k] <= v1pa_reg[k] + v1pb_reg[k];
            end
        end
    end

    // magnitudes and signs
    logic                v3v_reg;
    early_t              v3e_reg;
    logic [3:0][VW-1:0]  v3m_reg;
    logic [3:0]          v3neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3v_reg <= 1'b0;
        end else if (en) begin
            v3v_reg <= v2v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v3e_reg <= v2e_reg;
            for (int k = 0; k < 4; k++) begin
                v3neg_reg[k] <= v2v_data_reg[k][VW-1];
                v3m_reg[k]   <= v2v_data_reg[k][VW-1] ? -v2v_data_reg[k] : v2v_data_reg[k];
            end
        end
    end

    // bit length of the largest magnitude, taken from the or of all four
    logic                v4v_reg;
    early_t              v4e_reg;
    logic [3:0][VW-1:0]  v4m_reg;
    logic [3:0]          v4neg_reg;
    logic [5:0]          v4bl_reg;
    logic                v4z_reg;
    logic [VW-1:0]       orv;
    logic [5:0]          blen;

    always_comb begin
        orv  = v3m_reg[0] | v3m_reg[1] | v3m_reg[2] | v3m_reg[3];
        blen = '0;
        for (int j = 0; j < VW; j++) begin
            if (orv[j]) begin
                blen = 6'(j + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4v_reg <= 1'b0;
        end else if (en) begin
            v4v_reg <= v3v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v4e_reg   <= v3e_reg;
            v4m_reg   <= v3m_reg;
            v4neg_reg <= v3neg_reg;
            v4bl_reg  <= blen;
            v4z_reg   <= (orv == '0);
        end
    end

    // wide vectors shift down so the largest tops out at bit 29,
    // narrower ones move up by a single bit only
    logic                    v5v_reg;
    early_t                  v5e_reg;
    logic [3:0][NORM_W-1:0]  v5mn_reg;
    logic [3:0]              v5neg_reg;
    logic                    v5z_reg;
    logic [3:0][NORM_W-1:0]  mn_next;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (v4bl_reg > NORM_TOP) begin
                mn_next[k] = NORM_W'(v4m_reg[k] >> (v4bl_reg - NORM_TOP));
            end else if (v4bl_reg < NORM_TOP) begin
                mn_next[k] = NORM_W'(v4m_reg[k] << 1);
            end else begin
                mn_next[k] = NORM_W'(v4m_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5v_reg <= 1'b0;
        end else if (en) begin
            v5v_reg <= v4v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v5e_reg   <= v4e_reg;
            v5mn_reg  <= mn_next;
            v5neg_reg <= v4neg_reg;
            v5z_reg   <= v4z_reg;
        end
    end

    // squares
    logic                      v6v_reg;
    early_t                    v6e_reg;
    logic [3:0][NORM_W-1:0]    v6mn_reg;
    logic [3:0]                v6neg_reg;
    logic                      v6z_reg;
    logic [3:0][2*NORM_W-1:0]  v6sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6v_reg <= 1'b0;
        end else if (en) begin
            v6v_reg <= v5v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v6e_reg   <= v5e_reg;
            v6mn_reg  <= v5mn_reg;
            v6neg_reg <= v5neg_reg;
            v6z_reg   <= v5z_reg;
            for (int k = 0; k < 4; k++) begin
                v6sq_reg[k] <= (2*NORM_W)'(v5mn_reg[k]) * (2*NORM_W)'(v5mn_reg[k]);
            end
        end
    end

    // norm square root pipeline, stage 0 holds the sum of squares
    logic                    nv_reg   [0:SQ_STEPS];
    early_t                  ne_reg   [0:SQ_STEPS];
    logic [3:0][NORM_W-1:0]  nmn_reg  [0:SQ_STEPS];
    logic [3:0]              nneg_reg [0:SQ_STEPS];
    logic                    nz_reg   [0:SQ_STEPS];
    sq_t                     nsq_reg  [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg[0] <= 1'b0;
        end else if (en) begin
            nv_reg[0] <= v6v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ne_reg[0]       <= v6e_reg;
            nmn_reg[0]      <= v6mn_reg;
            nneg_reg[0]     <= v6neg_reg;
            nz_reg[0]       <= v6z_reg;
            nsq_reg[0].rem  <= SQ_W'(v6sq_reg[0]) + SQ_W'(v6sq_reg[1])
                             + SQ_W'(v6sq_reg[2]) + SQ_W'(v6sq_reg[3]);
            nsq_reg[0].root <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_nsq
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nv_reg[k+1] <= 1'b0;
            end else if (en) begin
                nv_reg[k+1] <= nv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ne_reg[k+1]   <= ne_reg[k];
                nmn_reg[k+1]  <= nmn_reg[k];
                nneg_reg[k+1] <= nneg_reg[k];
                nz_reg[k+1]   <= nz_reg[k];
                nsq_reg[k+1]  <= sq_step(nsq_reg[k], k);
            end
        end
    end

    // divider: stage 0 forms the rounded dividends
    logic                        dv_reg   [0:DIV_STEPS];
    early_t                      de_reg   [0:DIV_STEPS];
    logic [30:0]                 dn_reg   [0:DIV_STEPS];
    logic [3:0][DW-1:0]          drem_reg [0:DIV_STEPS];
    logic [3:0][DIV_STEPS-1:0]   dq_reg   [0:DIV_STEPS];
    logic [3:0]                  dneg_reg [0:DIV_STEPS];
    logic                        dz_reg   [0:DIV_STEPS];
    logic [30:0]                 norm_n;

    assign norm_n = nsq_reg[SQ_STEPS].root[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0] <= nv_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            de_reg[0]   <= ne_reg[SQ_STEPS];
            dn_reg[0]   <= norm_n;
            dneg_reg[0] <= nneg_reg[SQ_STEPS];
            dz_reg[0]   <= nz_reg[SQ_STEPS];
            dq_reg[0]   <= '0;
            for (int k = 0; k < 4; k++) begin
                drem_reg[0][k] <= (DW'(nmn_reg[SQ_STEPS][k]) << COMP_FRAC_BITS)
                                + DW'(norm_n >> 1);
            end
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [DW-1:0]               dsub;
        logic [3:0][DW-1:0]          rem_next;
        logic [3:0][DIV_STEPS-1:0]   q_next;

        // one quotient bit per lane, most significant first
        always_comb begin
            dsub = DW'(dn_reg[j]) << (DIV_STEPS - 1 - j);
            for (int k = 0; k < 4; k++) begin
                if (drem_reg[j][k] >= dsub) begin
                    rem_next[k] = drem_reg[j][k] - dsub;
                    q_next[k]   = {dq_reg[j][k][DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_next[k] = drem_reg[j][k];
                    q_next[k]   = {dq_reg[j][k][DIV_STEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= dv_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                de_reg[j+1]   <= de_reg[j];
                dn_reg[j+1]   <= dn_reg[j];
                dneg_reg[j+1] <= dneg_reg[j];
                dz_reg[j+1]   <= dz_reg[j];
                drem_reg[j+1] <= rem_next;
                dq_reg[j+1]   <= q_next;
            end
        end
    end

    // output register: saturate, restore signs, pick early or partial result
    logic [3:0][15:0] out_res_reg;
    outcome_t         out_outc_reg;
    logic [3:0][15:0] res_next;
    outcome_t         outc_next;
    early_t           fin_e;
    logic [DIV_STEPS-1:0] mag;

    assign fin_e = de_reg[DIV_STEPS];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mag = (dq_reg[DIV_STEPS][k] > MAG_ONE) ? MAG_ONE : dq_reg[DIV_STEPS][k];
            if (dz_reg[DIV_STEPS]) begin
                res_next[k] = '0;
            end else if (dneg_reg[DIV_STEPS][k]) begin
                res_next[k] = -{1'b0, mag};
            end else begin
                res_next[k] = {1'b0, mag};
            end
        end
        outc_next = OUT_STEP;
        if (fin_e.done) begin
            res_next  = fin_e.res;
            outc_next = fin_e.outc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_res_reg  <= res_next;
            out_outc_reg <= outc_next;
        end
    end

    assign m_res_w   = out_res_reg[0];
    assign m_res_x   = out_res_reg[1];
    assign m_res_y   = out_res_reg[2];
    assign m_res_z   = out_res_reg[3];
    assign m_outcome = out_outc_reg;

`ifndef SYNTH
    // partial step components never exceed unit magnitude
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_outcome == OUT_STEP) |->
            ($signed(m_res_w) <= 16'sd16384 && $signed(m_res_w) >= -16'sd16384 &&
             $signed(m_res_x) <= 16'sd16384 && $signed(m_res_x) >= -16'sd16384 &&
             $signed(m_res_y) <= 16'sd16384 && $signed(m_res_y) >= -16'sd16384 &&
             $signed(m_res_z) <= 16'sd16384 && $signed(m_res_z) >= -16'sd16384))
        else $error("partial step component out of range");

    // sine of the angle between the quaternions is at most one
    a_sin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cv_reg[SQ_STEPS] |-> (sin_a <= ONE30_U))
        else $error("first square root above one");

    // a nonzero vector has a nonzero norm
    a_norm_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (nv_reg[SQ_STEPS] && !nz_reg[SQ_STEPS]) |-> (norm_n != '0))
        else $error("zero norm for a nonzero vector");

    // a stalled pipeline keeps its output item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> (out_valid_reg && $stable(out_res_reg) && $stable(out_outc_reg)))
        else $error("output changed while stalled");
`endif

endmodule
